// ----- rtl/wn3_pkg.sv -----
// ----------------------------------------------------------------------------
// wn3_pkg: shared types and constants for the 3D wavelet noise evaluator
// Tile geometry, fixed-point widths, sequencer states, multiplier request
// tags and the small helper functions used by the sequencer and datapath.
// ----------------------------------------------------------------------------
package wn3_pkg;

  // Tile side, power of two, so the periodic wrap is a mask
  localparam int TILE_SIDE       = 32;
  localparam int COORD_FRAC_BITS = 16;

  localparam int SIDE_BITS    = $clog2(TILE_SIDE);
  localparam int ADDR_W       = 3 * SIDE_BITS;
  localparam int TILE_ENTRIES = TILE_SIDE * TILE_SIDE * TILE_SIDE;

  localparam int COORD_W  = 32;
  localparam int INDEX_W  = 15;
  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 16;   // axis weight, Q0.16
  localparam int PAIR_W   = 2 * WEIGHT_W;
  localparam int WT_W     = 24;   // three-weight product, Q0.24
  localparam int WT_SHIFT = 3 * WEIGHT_W - WT_W;

  // exact squares carry 2F fraction bits, plus room for 2.0
  localparam int SQ_W    = 2 * COORD_FRAC_BITS + 2;
  localparam int W_SHIFT = 2 * COORD_FRAC_BITS + 1 - WEIGHT_W;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = (COORD_FRAC_BITS + 2 > 18) ? COORD_FRAC_BITS + 2 : 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 44;    // 36 fraction bits plus headroom
  localparam int ACC_FRAC = WT_W + 12;
  localparam int RES_SHIFT = ACC_FRAC - 12;

  localparam int TERMS          = 27;
  localparam int SQUARE_STEPS   = 6;
  localparam int PAIR_STEPS     = 9;
  localparam int TERM_STEPS     = 2 * TERMS + 2;
  localparam int LAST_WGT_STEP  = 2 * (TERMS - 1);
  localparam int FIRST_COEF_STEP = 3;
  localparam int STEP_W         = $clog2(TERM_STEPS);

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // constant 0.5 in coordinate format, over the bits that matter for the cell
  localparam logic [COORD_FRAC_BITS+SIDE_BITS-1:0] COORD_HALF =
    (COORD_FRAC_BITS + SIDE_BITS)'(1) << (COORD_FRAC_BITS - 1);
  localparam logic [COORD_FRAC_BITS:0] COORD_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};
  localparam logic [SQ_W-1:0] SQ_FULL = {2'b10, {(2 * COORD_FRAC_BITS){1'b0}}};
  localparam logic [SQ_W:0]   W_RND   = {{SQ_W{1'b0}}, 1'b1} << (W_SHIFT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SETTLE,
    ST_PAIR,
    ST_TERM,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    TG_NONE,
    TG_SQ_A,
    TG_SQ_C,
    TG_PAIR,
    TG_WGT,
    TG_TERM
  } tag_kind_t;

  typedef struct packed {
    tag_kind_t  kind;
    logic [3:0] idx;    // axis for squares, pair slot for pairs
  } tag_t;

  // neighbor offsets, each 0..2
  typedef struct packed {
    logic [1:0] dz;
    logic [1:0] dy;
    logic [1:0] dx;
  } trit_t;

  typedef struct packed {
    tag_t  issue;
    trit_t mt;        // offsets for the multiplier operands
    trit_t rd_pos;    // offsets for the tile read
    logic  rd_en;
    logic  finish_load;
    logic  busy;
  } ctl_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    tag_t               tag;
  } mul_req_t;

  typedef struct packed {
    logic [MUL_P_W-1:0] p;
    tag_t               tag;
  } mul_rsp_t;

  typedef struct packed {
    logic [COORD_FRAC_BITS-1:0] t;
    logic [SIDE_BITS-1:0]       mid;
  } axis_t;

  function automatic trit_t next_xyz(input trit_t c);
    trit_t n;
    n = c;
    if (c.dx == 2'd2) begin
      n.dx = 2'd0;
      if (c.dy == 2'd2) begin
        n.dy = 2'd0;
        n.dz = (c.dz == 2'd2) ? 2'd0 : c.dz + 2'd1;
      end else begin
        n.dy = c.dy + 2'd1;
      end
    end else begin
      n.dx = c.dx + 2'd1;
    end
    return n;
  endfunction

  function automatic trit_t next_yz(input trit_t c);
    trit_t n;
    n = c;
    if (c.dy == 2'd2) begin
      n.dy = 2'd0;
      n.dz = (c.dz == 2'd2) ? 2'd0 : c.dz + 2'd1;
    end else begin
      n.dy = c.dy + 2'd1;
    end
    return n;
  endfunction

  // slot of the (dz, dy) weight pair: 3*dz + dy
  function automatic logic [3:0] pair_idx(input trit_t c);
    return {1'b0, c.dz, 1'b0} + {2'b00, c.dz} + {2'b00, c.dy};
  endfunction

  // round half up from 2F+1 fraction bits to Q0.16
  function automatic logic [WEIGHT_W-1:0] round_w(input logic [SQ_W-1:0] x);
    logic [SQ_W:0] s;
    s = {1'b0, x} + W_RND;
    return s[W_SHIFT+WEIGHT_W-1:W_SHIFT];
  endfunction

endpackage

// ----- rtl/wn3_ram.sv -----
// ----------------------------------------------------------------------------
// wn3_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wn3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule

// ----- rtl/wn3_mul.sv -----
// ----------------------------------------------------------------------------
// wn3_mul: shared signed multiplier
// Registered product; the request tag travels with it to the writeback.
// ----------------------------------------------------------------------------
module wn3_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  wn3_pkg::mul_req_t req,
  output wn3_pkg::mul_rsp_t rsp
);

  logic [wn3_pkg::MUL_P_W-1:0] p_r;
  wn3_pkg::tag_t               tag_r;

  always_ff @(posedge clk) begin
    p_r <= wn3_pkg::MUL_P_W'($signed(req.a) * $signed(req.b));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '{kind: wn3_pkg::TG_NONE, idx: 4'd0};
    end else begin
      tag_r <= req.tag;
    end
  end

  assign rsp.p   = p_r;
  assign rsp.tag = tag_r;

endmodule

// ----- rtl/wn3_ctrl.sv -----
// ----------------------------------------------------------------------------
// wn3_ctrl: evaluation sequencer
// Steps the shared multiplier through squares, weight pairs and the
// interleaved weight / coefficient products of the 27 neighbors.
// ----------------------------------------------------------------------------
module wn3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_operation,
  input  logic          out_free,
  output wn3_pkg::ctl_t ctl
);

  wn3_pkg::state_t            state_r, state_nxt;
  logic [wn3_pkg::STEP_W-1:0] step_r;
  wn3_pkg::trit_t             pc_r, wk_r, ck_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wn3_pkg::ST_IDLE: begin
        if (in_valid && (in_operation == wn3_pkg::OP_EVAL)) begin
          state_nxt = wn3_pkg::ST_SQUARE;
        end
      end
      wn3_pkg::ST_SQUARE: begin
        if (step_r == wn3_pkg::STEP_W'(wn3_pkg::SQUARE_STEPS - 1)) begin
          state_nxt = wn3_pkg::ST_SETTLE;
        end
      end
      wn3_pkg::ST_SETTLE: state_nxt = wn3_pkg::ST_PAIR;
      wn3_pkg::ST_PAIR: begin
        if (step_r == wn3_pkg::STEP_W'(wn3_pkg::PAIR_STEPS - 1)) begin
          state_nxt = wn3_pkg::ST_TERM;
        end
      end
      wn3_pkg::ST_TERM: begin
        if (step_r == wn3_pkg::STEP_W'(wn3_pkg::TERM_STEPS - 1)) begin
          state_nxt = wn3_pkg::ST_DRAIN;
        end
      end
      wn3_pkg::ST_DRAIN: state_nxt = wn3_pkg::ST_FINISH;
      wn3_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = wn3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wn3_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl             = '0;
    ctl.issue.kind  = wn3_pkg::TG_NONE;
    ctl.busy        = (state_r != wn3_pkg::ST_IDLE);
    case (state_r)
      wn3_pkg::ST_SQUARE: begin
        ctl.issue.kind = step_r[0] ? wn3_pkg::TG_SQ_C : wn3_pkg::TG_SQ_A;
        ctl.issue.idx  = 4'(step_r[wn3_pkg::STEP_W-1:1]);
      end
      wn3_pkg::ST_PAIR: begin
        ctl.issue.kind = wn3_pkg::TG_PAIR;
        ctl.issue.idx  = wn3_pkg::pair_idx(pc_r);
        ctl.mt         = pc_r;
      end
      wn3_pkg::ST_TERM: begin
        // even steps: weight product of term n, tile read of term n-1
        // odd steps: coefficient product of term n-1
        if (!step_r[0] && (step_r <= wn3_pkg::STEP_W'(wn3_pkg::LAST_WGT_STEP))) begin
          ctl.issue.kind = wn3_pkg::TG_WGT;
          ctl.mt         = wk_r;
        end
        if (!step_r[0] && (step_r != '0)) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_pos = ck_r;
        end
        if (step_r[0] && (step_r >= wn3_pkg::STEP_W'(wn3_pkg::FIRST_COEF_STEP))) begin
          ctl.issue.kind = wn3_pkg::TG_TERM;
        end
      end
      wn3_pkg::ST_FINISH: ctl.finish_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wn3_pkg::ST_IDLE;
      step_r  <= '0;
      pc_r    <= '0;
      wk_r    <= '0;
      ck_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 1'b1;
      end
      if (state_r == wn3_pkg::ST_SETTLE) begin
        pc_r <= '0;
      end else if (state_r == wn3_pkg::ST_PAIR) begin
        pc_r <= wn3_pkg::next_yz(pc_r);
      end
      if (state_r == wn3_pkg::ST_PAIR) begin
        wk_r <= '0;
        ck_r <= '0;
      end else begin
        if (ctl.issue.kind == wn3_pkg::TG_WGT) begin
          wk_r <= wn3_pkg::next_xyz(wk_r);
        end
        if (ctl.rd_en) begin
          ck_r <= wn3_pkg::next_xyz(ck_r);
        end
      end
    end
  end

endmodule

// ----- rtl/wavelet_noise_3d_eval.sv -----
// ----------------------------------------------------------------------------
// wavelet_noise_3d_eval: 3D wavelet noise evaluator, quadratic B-spline
// Periodic cubic tile of Q3.12 coefficients loaded by write transactions;
// evaluate transactions return the weighted 27-neighbor sum at a point.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | operation, coord_x/y/z, entry_index/value
//  out     | out_valid/out_stall| noise_value (Q3.12, rounded, saturated)
//
//  Write transaction: stored in the tile on the accepting edge.
//  Evaluate transaction: in_stall stays high from acceptance until the
//  result is loaded into the output register; the shared multiplier runs
//  6 squares, 9 weight pairs and 2 products per neighbor (27 neighbors).
//  The result sits in an output register; a new transaction can be taken
//  while it waits, but the next result waits for that register to empty.
//  rst_n is synchronous; the tile has no reset and must be read only where
//  written; that binds the user, the block itself does not enforce it.
module wavelet_noise_3d_eval (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic signed [wn3_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [wn3_pkg::COORD_W-1:0]   in_coord_y,
  input  logic signed [wn3_pkg::COORD_W-1:0]   in_coord_z,
  input  logic [wn3_pkg::INDEX_W-1:0]          in_entry_index,
  input  logic signed [wn3_pkg::VALUE_W-1:0]   in_entry_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wn3_pkg::VALUE_W-1:0]   out_noise_value
);

  localparam int F  = wn3_pkg::COORD_FRAC_BITS;
  localparam int SB = wn3_pkg::SIDE_BITS;
  localparam int RW = wn3_pkg::ACC_W - wn3_pkg::RES_SHIFT;

  wn3_pkg::ctl_t     ctl;
  wn3_pkg::mul_req_t req;
  wn3_pkg::mul_rsp_t rsp;

  logic in_acc, start, out_free;
  logic tile_we;
  logic [wn3_pkg::ADDR_W+wn3_pkg::INDEX_W-1:0] wr_idx_ext;
  logic [wn3_pkg::ADDR_W-1:0] rd_addr;
  logic [wn3_pkg::VALUE_W-1:0] ram_q;

  // per-axis point state
  logic [F-1:0]  t_r   [3];
  logic [SB-1:0] mid_r [3];
  logic [wn3_pkg::SQ_W-1:0] a_r [3];

  // Q0.16 weights, one row per axis
  logic [wn3_pkg::WEIGHT_W-1:0] w_x_r [3];
  logic [wn3_pkg::WEIGHT_W-1:0] w_y_r [3];
  logic [wn3_pkg::WEIGHT_W-1:0] w_z_r [3];
  logic [wn3_pkg::PAIR_W-1:0]   pair_r [9];
  logic [wn3_pkg::WT_W-1:0]     wt_r;
  logic signed [wn3_pkg::ACC_W-1:0] acc_r;

  logic                                out_valid_r;
  logic [wn3_pkg::VALUE_W-1:0]         out_noise_value_r;

  wn3_pkg::axis_t ax_x, ax_y, ax_z;

  // operand / writeback temporaries
  logic [F-1:0]             t_sel;
  logic [F:0]               omt;
  logic [wn3_pkg::SQ_W-1:0] sq_c, sq_b;
  logic [wn3_pkg::WEIGHT_W-1:0] wn0, wn1, wn2;
  logic [3*wn3_pkg::WEIGHT_W:0] wt_sum;
  logic signed [wn3_pkg::ACC_W-1:0] acc_rnd;
  logic signed [RW-1:0] res_full;
  logic [RW-16:0] res_hi;
  logic [wn3_pkg::VALUE_W-1:0] res_sat;
  logic [SB-1:0] cx, cy, cz;

  // cell of one axis: mid = ceil(p - 0.5), t = mid - (p - 0.5)
  function automatic wn3_pkg::axis_t axis_prep(input logic [wn3_pkg::COORD_W-1:0] p);
    logic [F+SB-1:0] q;
    logic [F-1:0]    frac;
    wn3_pkg::axis_t  r;
    q     = p[F+SB-1:0] - wn3_pkg::COORD_HALF;
    frac  = q[F-1:0];
    r.mid = q[F+SB-1:F] + SB'(frac != '0);
    r.t   = F'(~frac + 1'b1);
    return r;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (in_operation == wn3_pkg::OP_EVAL);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = ctl.busy;

  wn3_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_free     (out_free),
    .ctl          (ctl)
  );

  // tile writes beyond the tile are dropped
  assign wr_idx_ext = {{wn3_pkg::ADDR_W{1'b0}}, in_entry_index};
  assign tile_we    = in_acc && (in_operation == wn3_pkg::OP_WRITE) &&
                      (wr_idx_ext < (wn3_pkg::ADDR_W + wn3_pkg::INDEX_W)'(wn3_pkg::TILE_ENTRIES));

  // periodic wrap falls out of the SB-bit sums
  assign cx      = mid_r[0] + SB'(ctl.rd_pos.dx) - SB'(1);
  assign cy      = mid_r[1] + SB'(ctl.rd_pos.dy) - SB'(1);
  assign cz      = mid_r[2] + SB'(ctl.rd_pos.dz) - SB'(1);
  assign rd_addr = {cz, cy, cx};

  wn3_ram #(
    .WIDTH (wn3_pkg::VALUE_W),
    .DEPTH (wn3_pkg::TILE_ENTRIES)
  ) u_tile (
    .clk (clk),
    .we  (tile_we),
    .wa  (wn3_pkg::ADDR_W'(wr_idx_ext)),
    .wd  (in_entry_value),
    .re  (ctl.rd_en),
    .ra  (rd_addr),
    .q   (ram_q)
  );

  // shared multiplier operand select
  assign t_sel = t_r[ctl.issue.idx[1:0]];
  assign omt   = wn3_pkg::COORD_ONE - {1'b0, t_sel};

  always_comb begin
    req.a   = '0;
    req.b   = '0;
    req.tag = ctl.issue;
    case (ctl.issue.kind)
      wn3_pkg::TG_SQ_A: begin
        req.a = wn3_pkg::MUL_A_W'(t_sel);
        req.b = wn3_pkg::MUL_B_W'(t_sel);
      end
      wn3_pkg::TG_SQ_C: begin
        req.a = wn3_pkg::MUL_A_W'(omt);
        req.b = wn3_pkg::MUL_B_W'(omt);
      end
      wn3_pkg::TG_PAIR: begin
        req.a = wn3_pkg::MUL_A_W'(w_y_r[ctl.mt.dy]);
        req.b = wn3_pkg::MUL_B_W'(w_z_r[ctl.mt.dz]);
      end
      wn3_pkg::TG_WGT: begin
        req.a = wn3_pkg::MUL_A_W'(pair_r[wn3_pkg::pair_idx(ctl.mt)]);
        req.b = wn3_pkg::MUL_B_W'(w_x_r[ctl.mt.dx]);
      end
      wn3_pkg::TG_TERM: begin
        req.a = wn3_pkg::MUL_A_W'(wt_r);
        req.b = wn3_pkg::MUL_B_W'($signed(ram_q));
      end
      default: ;
    endcase
  end

  wn3_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // writeback arithmetic
  assign sq_c   = rsp.p[wn3_pkg::SQ_W-1:0];
  assign sq_b   = wn3_pkg::SQ_FULL - a_r[rsp.tag.idx[1:0]] - sq_c;
  assign wn0    = wn3_pkg::round_w(a_r[rsp.tag.idx[1:0]]);
  assign wn1    = wn3_pkg::round_w(sq_b);
  assign wn2    = wn3_pkg::round_w(sq_c);
  assign wt_sum = {1'b0, rsp.p[3*wn3_pkg::WEIGHT_W-1:0]} +
                  ((3 * wn3_pkg::WEIGHT_W + 1)'(1) << (wn3_pkg::WT_SHIFT - 1));

  assign ax_x = axis_prep(in_coord_x);
  assign ax_y = axis_prep(in_coord_y);
  assign ax_z = axis_prep(in_coord_z);

  always_ff @(posedge clk) begin
    if (start) begin
      t_r[0]   <= ax_x.t;
      t_r[1]   <= ax_y.t;
      t_r[2]   <= ax_z.t;
      mid_r[0] <= ax_x.mid;
      mid_r[1] <= ax_y.mid;
      mid_r[2] <= ax_z.mid;
      acc_r    <= '0;
    end else if (rsp.tag.kind == wn3_pkg::TG_TERM) begin
      acc_r <= acc_r + wn3_pkg::ACC_W'($signed(rsp.p));
    end
    case (rsp.tag.kind)
      wn3_pkg::TG_SQ_A: a_r[rsp.tag.idx[1:0]] <= sq_c;
      wn3_pkg::TG_SQ_C: begin
        case (rsp.tag.idx[1:0])
          wn3_pkg::AXIS_X: w_x_r <= '{wn0, wn1, wn2};
          wn3_pkg::AXIS_Y: w_y_r <= '{wn0, wn1, wn2};
          wn3_pkg::AXIS_Z: w_z_r <= '{wn0, wn1, wn2};
          default: ;
        endcase
      end
      wn3_pkg::TG_PAIR: pair_r[rsp.tag.idx] <= rsp.p[wn3_pkg::PAIR_W-1:0];
      wn3_pkg::TG_WGT:  wt_r <= wt_sum[wn3_pkg::WT_SHIFT+wn3_pkg::WT_W-1:wn3_pkg::WT_SHIFT];
      default: ;
    endcase
  end

  // round half up to Q3.12, then saturate
  assign acc_rnd  = acc_r + (wn3_pkg::ACC_W'(1) <<< (wn3_pkg::RES_SHIFT - 1));
  assign res_full = acc_rnd[wn3_pkg::ACC_W-1:wn3_pkg::RES_SHIFT];
  assign res_hi   = res_full[RW-1:15];

  always_comb begin
    if ((&res_hi) || !(|res_hi)) begin
      res_sat = res_full[15:0];
    end else if (res_full[RW-1]) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = 16'h7fff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish_load) begin
      out_noise_value_r <= res_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

endmodule

// ----- rtl/wn3_checker.sv -----
// ----------------------------------------------------------------------------
// wn3_checker: port-level checks for the wavelet noise evaluator
// Output hold rules, evaluate/write stall behavior and an early-result check.
// ----------------------------------------------------------------------------
module wn3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_noise_value))
    else $error("out_noise_value changed while stalled");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == wn3_pkg::OP_EVAL) |=> in_stall)
    else $error("evaluate transaction did not make the block busy");

  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == wn3_pkg::OP_WRITE) |=> !in_stall)
    else $error("write transaction stalled the input");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == wn3_pkg::OP_EVAL) |=> !$rose(out_valid))
    else $error("result appeared right after an evaluate transaction");

endmodule

bind wavelet_noise_3d_eval wn3_checker u_wn3_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3D wavelet noise evaluator
// Loads tile coefficients and evaluates points through the valid/stall
// channels, predicts each noise sum with an in-bench bit-accurate model of
// the quadratic B-spline reconstruction, and compares results in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int ITEM_TARGET  = 1550;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int FB = wn3_pkg::COORD_FRAC_BITS;
  localparam int SB = wn3_pkg::SIDE_BITS;
  localparam int COORD_W      = wn3_pkg::COORD_W;
  localparam int INDEX_W      = wn3_pkg::INDEX_W;
  localparam int VALUE_W      = wn3_pkg::VALUE_W;
  localparam int WEIGHT_W     = wn3_pkg::WEIGHT_W;
  localparam int WT_SHIFT     = wn3_pkg::WT_SHIFT;
  localparam int RES_SHIFT    = wn3_pkg::RES_SHIFT;
  localparam int TILE_SIDE    = wn3_pkg::TILE_SIDE;
  localparam int TILE_ENTRIES = wn3_pkg::TILE_ENTRIES;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_operation;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic [INDEX_W-1:0]        in_entry_index;
  logic signed [VALUE_W-1:0] in_entry_value;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_noise_value;

  wavelet_noise_3d_eval dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_noise_value(out_noise_value)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Bench copy of the tile plus a map of which entries hold a real value.
  // Evaluations only go out once all 27 neighbors have been written.
  logic signed [VALUE_W-1:0] tile_copy [TILE_ENTRIES];
  bit                        entry_written [TILE_ENTRIES];

  logic signed [VALUE_W-1:0] pending_noise [$];   // expected results, oldest first
  int                        error_count = 0;
  int                        items_sent  = 0;
  int                        cycle_count = 0;
  bit                        steady_flow = 1'b0;  // no idling on either side
  logic signed [VALUE_W-1:0] want_noise;

  // append one expected result behind the older ones
  function automatic void add_expected(input logic signed [VALUE_W-1:0] v);
    pending_noise = {pending_noise, v};
  endfunction

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // One axis: centre cell (wrapped) and the three Q0.16 spline weights.
  // q = p - 0.5; mid = ceil(q); t = mid - q, so an integral q gives t = 0.
  function automatic void axis_split(input logic signed [COORD_W-1:0] p,
                                     output logic [SB-1:0] ctr,
                                     output logic [2:0][WEIGHT_W-1:0] w);
    longint      q, fl;
    logic [63:0] one, t, a, b, c, rnd;
    int          sh;
    sh  = 2 * FB + 1 - WEIGHT_W;
    one = 64'd1 << FB;
    rnd = 64'd1 << (sh - 1);
    q   = longint'(p) - (longint'(1) <<< (FB - 1));
    fl  = q >>> FB;
    t   = 64'(q - (fl <<< FB));
    if (t == 0) begin
      ctr = SB'(fl);
    end else begin
      ctr = SB'(fl + 1);
      t   = one - t;
    end
    a = t * t;
    c = (one - t) * (one - t);
    b = 64'd2 * one * one - a - c;
    w[0] = WEIGHT_W'((a + rnd) >> sh);
    w[1] = WEIGHT_W'((b + rnd) >> sh);
    w[2] = WEIGHT_W'((c + rnd) >> sh);
  endfunction

  // tile entry of neighbor (dx, dy, dz), each 0..2 around the centre cell
  function automatic logic [INDEX_W-1:0] neighbor_entry(input logic [SB-1:0] cx, cy, cz,
                                                        input int dx, dy, dz);
    logic [SB-1:0] ex, ey, ez;
    ex = SB'(int'(cx) + dx - 1);
    ey = SB'(int'(cy) + dy - 1);
    ez = SB'(int'(cz) + dz - 1);
    return INDEX_W'({ez, ey, ex});
  endfunction

  function automatic logic signed [VALUE_W-1:0] predict_noise(
      input logic signed [COORD_W-1:0] x, y, z);
    logic [SB-1:0]               cx, cy, cz;
    logic [2:0][WEIGHT_W-1:0]    wx, wy, wz;
    logic [63:0]                 prod;
    longint                      acc, wt, r;
    acc = 0;
    axis_split(x, cx, wx);
    axis_split(y, cy, wy);
    axis_split(z, cz, wz);
    for (int dz = 0; dz < 3; dz++)
      for (int dy = 0; dy < 3; dy++)
        for (int dx = 0; dx < 3; dx++) begin
          prod = 64'(wx[dx]) * 64'(wy[dy]) * 64'(wz[dz]);
          wt   = longint'((prod + (64'd1 << (WT_SHIFT - 1))) >> WT_SHIFT);
          acc += wt * longint'(tile_copy[neighbor_entry(cx, cy, cz, dx, dy, dz)]);
        end
    // round half toward +inf down to Q3.12, then clamp
    r = (acc + (longint'(1) <<< (RES_SHIFT - 1))) >>> RES_SHIFT;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return VALUE_W'(r);
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // coefficients: mostly random, sometimes full scale for saturation
  function automatic logic signed [VALUE_W-1:0] rand_value();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return VALUE_W'($urandom());
  endfunction

  // hot region: cells 30..3 around the wrap point, reused by most evaluates
  function automatic logic [SB-1:0] hot_cell();
    return SB'(TILE_SIDE - 2 + $urandom_range(0, 5));
  endfunction

  // random upper bits, integer part ending in 31, 0 or 1 (centre cell 31..2)
  function automatic logic signed [COORD_W-1:0] hot_coord();
    logic [COORD_W-1:0] r;
    logic [FB-1:0]      frac;
    frac = FB'($urandom());
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: frac = '0;                          // exact integer, t = 0.5
        1: frac = FB'(1) << (FB - 1);          // half, t = 0
        2: frac = (FB'(1) << (FB - 1)) - 1'b1;
        3: frac = (FB'(1) << (FB - 1)) + 1'b1;
        4: frac = '1;
        default: frac = FB'(1);
      endcase
    end
    r = $urandom();
    r[FB+SB-1:0] = {SB'(TILE_SIDE - 1 + $urandom_range(0, 2)), frac};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------

  // Drive one transaction and hold it until accepted. Valid stays high on
  // return; the caller's next action in the same step is another offer or
  // lowering valid.
  task automatic offer(input logic op, input logic [COORD_W-1:0] x, y, z,
                       input logic [INDEX_W-1:0] entry, input logic [VALUE_W-1:0] value);
    while (!steady_flow && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    in_entry_index <= entry;
    in_entry_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // unused payload fields carry random bits
  task automatic send_write(input logic [INDEX_W-1:0] entry,
                            input logic signed [VALUE_W-1:0] value);
    offer(wn3_pkg::OP_WRITE, $urandom(), $urandom(), $urandom(), entry, value);
    if (entry < TILE_ENTRIES) begin
      tile_copy[entry]     = value;
      entry_written[entry] = 1'b1;
    end
  endtask

  task automatic send_eval(input logic signed [COORD_W-1:0] x, y, z,
                           input bit typed, input logic signed [VALUE_W-1:0] typed_noise);
    logic signed [VALUE_W-1:0] noise;
    noise = typed ? typed_noise : predict_noise(x, y, z);
    offer(wn3_pkg::OP_EVAL, x, y, z, INDEX_W'($urandom()), VALUE_W'($urandom()));
    add_expected(noise);
  endtask

  // Write the 27 neighbors of a point: all of them with one value, or only
  // the unwritten ones with random values ahead of an evaluate.
  task automatic load_neighbors(input logic signed [COORD_W-1:0] x, y, z,
                                input bit overwrite, input logic signed [VALUE_W-1:0] value);
    logic [SB-1:0]            cx, cy, cz;
    logic [2:0][WEIGHT_W-1:0] w;
    logic [INDEX_W-1:0]       e;
    axis_split(x, cx, w);
    axis_split(y, cy, w);
    axis_split(z, cz, w);
    for (int dz = 0; dz < 3; dz++)
      for (int dy = 0; dy < 3; dy++)
        for (int dx = 0; dx < 3; dx++) begin
          e = neighbor_entry(cx, cy, cz, dx, dy, dz);
          if (overwrite)
            send_write(e, value);
          else if (!entry_written[e])
            send_write(e, rand_value());
        end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed script
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ROW_WRITE,   // one tile entry
    ROW_FILL,    // all 27 neighbors of the point get entry value
    ROW_EVAL     // evaluate; typed rows carry their result
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COORD_W-1:0]        z;
    logic [INDEX_W-1:0]        entry;
    logic [VALUE_W-1:0]        value;
    logic                      typed;
    logic [VALUE_W-1:0]        noise;
  } script_row_t;

  localparam int SCRIPT_ROWS = 19;
  script_row_t script [SCRIPT_ROWS];

  initial begin : stimulus
    logic signed [COORD_W-1:0] x, y, z;
    logic [INDEX_W-1:0]        entry;
    int                        roll;
    bit                        drained_once;

    drained_once = 1'b0;
    // Integer points give t = 0.5 on every axis: weights 1/8, 3/4, 1/8, exact,
    // so a uniform neighborhood returns its own value. At half points t = 0
    // and the weights are 0, 1/2, 1/2. Most negative coordinates land on
    // cell 0 with t = 0.5; the largest wrap through cell 0 as well.
    script = '{
      '{ROW_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
      '{ROW_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h8000, 1'b0, 16'h0000},
      '{ROW_FILL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h7FFF, 1'b0, 16'h0000},
      '{ROW_EVAL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h0000, 1'b1, 16'h7FFF},
      '{ROW_FILL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h8000, 1'b0, 16'h0000},
      '{ROW_EVAL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h0000, 1'b1, 16'h8000},
      '{ROW_EVAL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h0000, 16'h0000, 1'b1, 16'h8000},
      '{ROW_EVAL,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_FILL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h0000, 1'b0, 16'h0000},
      // large x that wraps onto cell 0, zero neighborhood
      '{ROW_EVAL,  32'h1220_5678, 32'hFFFF_FFFF, 32'h0000_0001, 15'h0000, 16'h0000, 1'b1, 16'h0000},
      '{ROW_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h1000, 1'b0, 16'h0000},
      // lone 1.0 at the centre: 0.75^3 * 4096
      '{ROW_EVAL,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h0000, 16'h0000, 1'b1, 16'h06C0},
      // half points, t = 0: 0.5^3 * 4096
      '{ROW_EVAL,  32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 15'h0000, 16'h0000, 1'b1, 16'h0200},
      '{ROW_EVAL,  32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_7FFF, 15'h0000, 16'h0000, 1'b0, 16'h0000},
      // neighborhood of cell 31, spanning the wrap
      '{ROW_FILL,  32'h001F_0000, 32'h001F_0000, 32'h001F_0000, 15'h0000, 16'h0800, 1'b0, 16'h0000},
      '{ROW_WRITE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 15'h001F, 16'hC000, 1'b0, 16'h0000},
      '{ROW_EVAL,  32'h001F_8000, 32'h001F_0000, 32'hFFFF_0000, 15'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_EVAL,  32'h7FFF_8000, 32'hFFFF_0000, 32'h001F_0000, 15'h0000, 16'h0000, 1'b0, 16'h0000},
      '{ROW_EVAL,  32'h0000_7FFF, 32'hFFFF_8001, 32'h0000_FFFF, 15'h0000, 16'h0000, 1'b0, 16'h0000}
    };

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = wn3_pkg::OP_WRITE;
    in_coord_x     = '0;
    in_coord_y     = '0;
    in_coord_z     = '0;
    in_entry_index = '0;
    in_entry_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_WRITE: send_write(script[i].entry, script[i].value);
        ROW_FILL:  load_neighbors(script[i].x, script[i].y, script[i].z, 1'b1, script[i].value);
        default: begin
          load_neighbors(script[i].x, script[i].y, script[i].z, 1'b0, '0);
          send_eval(script[i].x, script[i].y, script[i].z, script[i].typed, script[i].noise);
        end
      endcase
    end
    wait_drained();

    // Random part. Most evaluates stay in the hot region near the wrap so
    // they reuse written entries; a few use arbitrary points and first load
    // whatever neighbors are still unwritten.
    while (items_sent < ITEM_TARGET) begin
      steady_flow = (items_sent >= 700 && items_sent < 950);
      if (!drained_once && items_sent >= 400) begin
        wait_drained();
        drained_once = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        if ($urandom_range(0, 1))
          entry = INDEX_W'($urandom_range(0, TILE_ENTRIES - 1));
        else
          entry = INDEX_W'({hot_cell(), hot_cell(), hot_cell()});
        send_write(entry, rand_value());
      end else begin
        if (roll < 37) begin
          x = $urandom();
          y = $urandom();
          z = $urandom();
        end else begin
          x = hot_coord();
          y = hot_coord();
          z = hot_coord();
        end
        load_neighbors(x, y, z, 1'b0, '0);
        send_eval(x, y, z, 1'b0, '0);
      end
    end
    steady_flow = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result channel: random stall, in-order compare against the expectations
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_noise.size() == 0) begin
        $display("%0t: noise result %0d with no transaction outstanding",
                 $time, out_noise_value);
        error_count++;
      end else begin
        want_noise = pending_noise.pop_front();
        if (out_noise_value !== want_noise) begin
          $display("%0t: noise_value mismatch: expected %0d, actual %0d",
                   $time, want_noise, out_noise_value);
          error_count++;
        end
      end
    end
    out_stall <= !steady_flow && ($urandom_range(0, 99) < 25);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
